>>> rtl/rpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared constants, codes and types of the reference-counted page allocator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int PAGE_COUNT_DEF = 512;
  localparam int COUNT_BITS_DEF = 8;

  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;
  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

  // fixed field widths
  localparam int CMD_W  = 2;
  localparam int IDX_W  = 9;
  localparam int STAT_W = 3;
  localparam int OCNT_W = 8;
  localparam int CFG_W  = 9;

  localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADDREF  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTALLOC = 3'd2;
  localparam logic [STAT_W-1:0] ST_SAT      = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

  // lowest clear bit of a bitmap word
  typedef struct packed {
    logic             free;
    logic [BIT_W-1:0] pos;
  } find_t;

endpackage

>>> rtl/rpa_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_find
// Priority encoder that locates the lowest free page in one bitmap word.
// ----------------------------------------------------------------------------
module rpa_find (
  input  logic [rpa_pkg::WORD_BITS-1:0] word,
  output rpa_pkg::find_t                res
);

  always_comb begin
    res.free = (word != rpa_pkg::FULL_WORD);
    res.pos  = '0;
    for (int i = rpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.pos = rpa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

>>> rtl/refcounted_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_page_allocator_unit
// Bitmap page allocator with a reference count per page.
// ----------------------------------------------------------------------------
// One command is in work at a time. Add reference and release pass from
// transfer to result through a read, then a modify and write back through
// the bitmap and count memories, then the output register; an out-of-range
// page goes straight to the output register. Allocate scans one bitmap
// word per cycle through the bitmap memory port, up to the first word with
// a free page or the last word. Init rewrites every bitmap word, one per
// cycle. After reset a clearing pass empties the bitmap; no command is
// taken during it, configuration writes are. Each bitmap word also carries
// a per-page bit telling whether the stored count is live, so init never
// has to sweep the count memory.
module refcounted_page_allocator_unit #(
  parameter int PAGE_COUNT = rpa_pkg::PAGE_COUNT_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rpa_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rpa_pkg::CMD_W-1:0]   command,
  input  logic [rpa_pkg::IDX_W-1:0]   page_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rpa_pkg::IDX_W-1:0]   page_number,
  output logic [rpa_pkg::STAT_W-1:0]  status,
  output logic [rpa_pkg::OCNT_W-1:0]  ref_count
);

  localparam int WB        = rpa_pkg::WORD_BITS;
  localparam int BW        = rpa_pkg::BIT_W;
  localparam int PAGE_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int WIDE_W    = ((PAGE_W > rpa_pkg::IDX_W) ? PAGE_W : rpa_pkg::IDX_W) + 1;
  localparam int MAP_WORDS = (PAGE_COUNT + WB - 1) / WB;
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CW        = (COUNT_BITS > rpa_pkg::OCNT_W) ? COUNT_BITS : rpa_pkg::OCNT_W;

  localparam logic [WORD_AW-1:0]    LAST_W    = WORD_AW'(MAP_WORDS - 1);
  localparam logic [WIDE_W-1:0]     PAGES_W   = WIDE_W'(PAGE_COUNT);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_SCAN_ISSUE, S_SCAN, S_ACC_RD, S_ACC_MOD, S_RESP
  } state_t;

  state_t state;

  logic [rpa_pkg::CFG_W-1:0]  reserved;
  logic [rpa_pkg::CMD_W-1:0]  cmd_q;
  logic [rpa_pkg::IDX_W-1:0]  idx_q;
  logic                       sweep_clear;
  logic [WORD_AW-1:0]         sweep_w;
  logic [WORD_AW-1:0]         rd_w;
  logic [WORD_AW-1:0]         chk_w;
  logic [rpa_pkg::IDX_W-1:0]  res_page;
  logic [rpa_pkg::STAT_W-1:0] res_status;
  logic [rpa_pkg::OCNT_W-1:0] res_count;

  // bitmap memory: {live bits, used bits} per word
  logic [2*WB-1:0]       map_mem [MAP_WORDS];
  logic [2*WB-1:0]       map_rd_data;
  logic [WORD_AW-1:0]    map_rd_addr;
  logic                  map_we;
  logic [WORD_AW-1:0]    map_wr_addr;
  logic [2*WB-1:0]       map_wr_data;

  logic [COUNT_BITS-1:0] cnt_mem [PAGE_COUNT];
  logic [COUNT_BITS-1:0] cnt_rd_data;
  logic [PAGE_W-1:0]     cnt_rd_addr;
  logic                  cnt_we;
  logic [PAGE_W-1:0]     cnt_wr_addr;
  logic [COUNT_BITS-1:0] cnt_wr_data;

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wr_addr] <= map_wr_data;
    end
    map_rd_data <= map_mem[map_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wr_addr] <= cnt_wr_data;
    end
    cnt_rd_data <= cnt_mem[cnt_rd_addr];
  end

  // ---- init mask for the word being swept
  logic [WIDE_W-1:0] reserved_ext;
  logic [WIDE_W-1:0] last_clip;
  logic [WIDE_W-6:0] sweep_ext;
  logic [WB-1:0]     init_mask;

  always_comb begin
    reserved_ext = WIDE_W'(reserved);
    last_clip    = (reserved_ext >= PAGES_W) ? PAGES_W - WIDE_W'(1) : reserved_ext;
    sweep_ext    = (WIDE_W-5)'(sweep_w);
    if (sweep_clear || sweep_ext > last_clip[WIDE_W-1:BW]) begin
      init_mask = '0;
    end else if (sweep_ext < last_clip[WIDE_W-1:BW]) begin
      init_mask = rpa_pkg::FULL_WORD;
    end else begin
      init_mask = rpa_pkg::FULL_WORD >> (BW'(WB - 1) - last_clip[BW-1:0]);
    end
  end

  // ---- allocation scan
  rpa_pkg::find_t fr;
  logic [WIDE_W-1:0] scan_page;
  logic              alloc_hit;
  logic [WB-1:0]     alloc_bit;

  rpa_find u_find (
    .word (map_rd_data[WB-1:0]),
    .res  (fr)
  );

  always_comb begin
    scan_page = {(WIDE_W-5)'(chk_w), fr.pos};
    alloc_hit = fr.free && (scan_page < PAGES_W);
    alloc_bit = WB'(1) << fr.pos;
  end

  // ---- add reference / release on one page
  logic [WIDE_W-1:0]     idx_ext;
  logic [WORD_AW-1:0]    idx_word;
  logic [BW-1:0]         idx_bit;
  logic [WB-1:0]         used_word;
  logic [WB-1:0]         live_word;
  logic                  used_b;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [2*WB-1:0]       new_word;
  logic [WB-1:0]         page_bit;
  logic                  sat;
  logic [rpa_pkg::STAT_W-1:0] mod_status;
  logic [COUNT_BITS-1:0] mod_cnt;

  always_comb begin
    idx_ext   = WIDE_W'(idx_q);
    idx_word  = idx_ext[WORD_AW+BW-1:BW];
    idx_bit   = idx_q[BW-1:0];
    used_word = map_rd_data[WB-1:0];
    live_word = map_rd_data[2*WB-1:WB];
    page_bit  = WB'(1) << idx_bit;
    used_b    = used_word[idx_bit];
    cur_cnt   = live_word[idx_bit] ? cnt_rd_data : '0;
    sat       = (cmd_q == rpa_pkg::CMD_ADDREF) && (cur_cnt == COUNT_MAX);
    new_word  = map_rd_data;
    if (cmd_q == rpa_pkg::CMD_ADDREF) begin
      new_cnt  = sat ? cur_cnt : cur_cnt + COUNT_BITS'(1);
      new_word = map_rd_data | {page_bit, {WB{1'b0}}};
    end else begin
      new_cnt = (cur_cnt != '0) ? cur_cnt - COUNT_BITS'(1) : '0;
      if (new_cnt == '0) begin
        new_word = map_rd_data & ~{page_bit, page_bit};
      end
    end
    if (!used_b) begin
      mod_status = rpa_pkg::ST_NOTALLOC;
      mod_cnt    = cur_cnt;
    end else if (sat) begin
      mod_status = rpa_pkg::ST_SAT;
      mod_cnt    = cur_cnt;
    end else begin
      mod_status = rpa_pkg::ST_OK;
      mod_cnt    = new_cnt;
    end
  end

  logic [CW-1:0] mod_cnt_ext;
  assign mod_cnt_ext = CW'(mod_cnt);

  // ---- memory ports
  always_comb begin
    map_rd_addr = (state == S_SCAN_ISSUE || state == S_SCAN) ? rd_w : idx_word;
    cnt_rd_addr = idx_ext[PAGE_W-1:0];
    map_we      = 1'b0;
    map_wr_addr = sweep_w;
    map_wr_data = {{WB{1'b0}}, init_mask};
    cnt_we      = 1'b0;
    cnt_wr_addr = idx_ext[PAGE_W-1:0];
    cnt_wr_data = new_cnt;
    case (state)
      S_SWEEP: begin
        map_we = 1'b1;
      end
      S_SCAN: begin
        if (alloc_hit) begin
          map_we      = 1'b1;
          map_wr_addr = chk_w;
          map_wr_data = map_rd_data | {alloc_bit, alloc_bit};
          cnt_we      = 1'b1;
          cnt_wr_addr = scan_page[PAGE_W-1:0];
          cnt_wr_data = COUNT_BITS'(1);
        end
      end
      S_ACC_MOD: begin
        if (used_b) begin
          map_we      = 1'b1;
          map_wr_addr = idx_word;
          map_wr_data = new_word;
          cnt_we      = !sat;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      sweep_clear <= 1'b1;
      sweep_w     <= '0;
      reserved    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reserved <= cfg_data;
      end
      // output register loads when empty or when its transfer happens now
      if (state == S_RESP && (!out_valid || out_ready)) begin
        out_valid   <= 1'b1;
        page_number <= res_page;
        status      <= res_status;
        ref_count   <= res_count;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep_w == LAST_W) begin
            state <= sweep_clear ? S_IDLE : S_RESP;
          end else begin
            sweep_w <= sweep_w + WORD_AW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= command;
            idx_q      <= page_index;
            res_page   <= page_index;
            res_count  <= '0;
            res_status <= (WIDE_W'(page_index) >= PAGES_W) ? rpa_pkg::ST_RANGE
                                                           : rpa_pkg::ST_OK;
            case (command)
              rpa_pkg::CMD_INIT: begin
                sweep_clear <= 1'b0;
                sweep_w     <= '0;
                state       <= S_SWEEP;
              end
              rpa_pkg::CMD_ALLOC: begin
                rd_w  <= '0;
                state <= S_SCAN_ISSUE;
              end
              default: begin
                state <= (WIDE_W'(page_index) >= PAGES_W) ? S_RESP : S_ACC_RD;
              end
            endcase
          end
        end
        S_SCAN_ISSUE: begin
          chk_w <= rd_w;
          if (rd_w != LAST_W) begin
            rd_w <= rd_w + WORD_AW'(1);
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (fr.free || chk_w == LAST_W) begin
            if (alloc_hit) begin
              res_page   <= scan_page[rpa_pkg::IDX_W-1:0];
              res_status <= rpa_pkg::ST_OK;
              res_count  <= rpa_pkg::OCNT_W'(1);
            end else begin
              res_page   <= '0;
              res_status <= rpa_pkg::ST_NOFREE;
              res_count  <= '0;
            end
            state <= S_RESP;
          end else begin
            chk_w <= rd_w;
            if (rd_w != LAST_W) begin
              rd_w <= rd_w + WORD_AW'(1);
            end
          end
        end
        S_ACC_RD: begin
          state <= S_ACC_MOD;
        end
        S_ACC_MOD: begin
          res_status <= mod_status;
          res_count  <= mod_cnt_ext[rpa_pkg::OCNT_W-1:0];
          state      <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/rpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rpa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rpa_pkg::IDX_W-1:0]   page_number,
  input logic [rpa_pkg::STAT_W-1:0]  status,
  input logic [rpa_pkg::OCNT_W-1:0]  ref_count
);

  // failed allocation reports page zero with no count
  a_nofree: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rpa_pkg::ST_NOFREE |-> page_number == '0 && ref_count == '0)
    else $error("no-free result carries page or count");

  // out-of-range results never report a count
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rpa_pkg::ST_RANGE |-> ref_count == '0)
    else $error("out-of-range result carries a count");

  // a stalled result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(page_number) && $stable(status)
                                && $stable(ref_count))
    else $error("stalled result changed");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind refcounted_page_allocator_unit rpa_checker u_rpa_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .page_number (page_number),
  .status      (status),
  .ref_count   (ref_count)
);
